[rtl/first_fit_heap_allocator_top_defines.svh]
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FFH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define FFH_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`endif

[rtl/ffha_pkg.sv]
package ffha_pkg;
	localparam int unsigned StatusW = 3;
	localparam logic [StatusW-1:0] ST_OK = 3'd0;
	localparam logic [StatusW-1:0] ST_NOFIT = 3'd1;
	localparam logic [StatusW-1:0] ST_ZERO = 3'd2;
	localparam logic [StatusW-1:0] ST_FREED = 3'd3;
	localparam logic [StatusW-1:0] ST_RANGE = 3'd4;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;
	localparam int unsigned RegIdxW = 1;
	localparam logic [RegIdxW-1:0] REG_BASE = 1'b0;
	localparam logic [RegIdxW-1:0] REG_UNITS = 1'b1;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_INIT   = 14'b00000000000010,
		S_ARD    = 14'b00000000000100,
		S_AEVAL  = 14'b00000000001000,
		S_SPLIT  = 14'b00000000010000,
		S_RLRD   = 14'b00000000100000,
		S_RLWR   = 14'b00000001000000,
		S_FRD    = 14'b00000010000000,
		S_FEVAL  = 14'b00000100000000,
		S_NXRD   = 14'b00001000000000,
		S_PVRD   = 14'b00010000000000,
		S_MERGE  = 14'b00100000000000,
		S_FWR    = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} state_t;

	typedef enum logic [3:0] {
		C_NONE, C_INIT, C_RD_OFF, C_RD_NX, C_RD_PV, C_SPLIT, C_EXACT, C_ADV,
		C_RL_RD, C_RL_WR, C_NX_EVAL, C_PV_EVAL, C_FREE_WR
	} cmd_t;

	typedef struct packed {
		logic         at_end;
		logic         hdr_free;
		logic         fits_exact;
		logic         fits_split;
		logic         on_target;
		logic         past_target;
		logic         rl_in;
		logic         pv_ok;
		logic         addr_bad;
	} stat_t;
endpackage

[rtl/first_fit_heap_allocator_top.sv]
// channel   ports                                          transfer
// input     start, busy, operation, request_units,         start && !busy
//           payload_address
// result    done, result_address, status                   done
// config    cfg_we, cfg_idx, cfg_data                      cfg_we
// allocate: each header is read (S_ARD) and checked (S_AEVAL); an exact fit then
// answers, a split relinks the rest first; a zero size answers in the cycle after
// the transfer. free: each header is read (S_FRD) and checked (S_FEVAL); the block
// is merged and relinked before the answer unless it is already free or no header
// matches. reset and each config write rebuild the single free block in S_INIT.
// results cannot be stalled; done is high for one cycle, busy drops the cycle after
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top #(
	parameter int unsigned HEAP_UNITS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [11:0] request_units,
	input  logic [16:0] payload_address,
	output logic        done,
	output logic [16:0] result_address,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic [ffha_pkg::RegIdxW-1:0] cfg_idx,
	input  logic [15:0] cfg_data
);
	ffha_pkg::cmd_t cmd;
	ffha_pkg::stat_t st;
	logic go;

	assign go = start && !busy;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(go), .operation(operation),
		.req_zero(request_units == 12'd0), .cfg_we(cfg_we), .st(st), .cmd(cmd),
		.busy(busy), .done(done), .status(status)
	);

	ffha_dp #(.HEAP_UNITS(HEAP_UNITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .start_go(go),
		.request_units(request_units), .payload_address(payload_address),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done),
		.status(status), .st(st), .result_address(result_address)
	);

	`FFH_ASSERT(a_no_go_busy, clk, arst_n, go |=> busy)
	`FFH_ASSERT(a_fail_zero, clk, arst_n,
		(done && status != ffha_pkg::ST_OK) |-> result_address == 17'd0)
	`FFH_ASSERT(a_status_range, clk, arst_n, done |-> status <= ffha_pkg::ST_RANGE)
endmodule

[rtl/ffha_ctrl.sv]
`include "first_fit_heap_allocator_top_defines.svh"
module ffha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             operation,
	input  logic             req_zero,
	input  logic             cfg_we,
	input  ffha_pkg::stat_t  st,
	output ffha_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done,
	output logic [ffha_pkg::StatusW-1:0] status
);
	ffha_pkg::state_t state_q, nxt;
	logic [ffha_pkg::StatusW-1:0] status_q, status_d;
	logic is_free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_INIT;
			status_q <= ffha_pkg::ST_OK;
			is_free_q <= 1'b0;
		end else begin
			state_q <= nxt;
			status_q <= status_d;
			if (state_q == ffha_pkg::S_IDLE && start)
				is_free_q <= operation;
		end
	end

	always_comb begin
		nxt = state_q;
		cmd = ffha_pkg::C_NONE;
		status_d = status_q;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (cfg_we) begin
					nxt = ffha_pkg::S_INIT;
				end else if (start) begin
					status_d = ffha_pkg::ST_OK;
					if (operation == ffha_pkg::OP_ALLOC) begin
						if (req_zero) begin
							status_d = ffha_pkg::ST_ZERO;
							nxt = ffha_pkg::S_DONE;
						end else begin
							cmd = ffha_pkg::C_RD_OFF;
							nxt = ffha_pkg::S_ARD;
						end
					end else begin
						cmd = ffha_pkg::C_RD_OFF;
						nxt = ffha_pkg::S_FRD;
					end
				end
			end
			ffha_pkg::S_INIT: begin
				cmd = ffha_pkg::C_INIT;
				nxt = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_ARD: nxt = ffha_pkg::S_AEVAL;
			ffha_pkg::S_AEVAL: begin
				if (st.hdr_free && st.fits_exact) begin
					cmd = ffha_pkg::C_EXACT;
					nxt = ffha_pkg::S_DONE;
				end else if (st.hdr_free && st.fits_split) begin
					cmd = ffha_pkg::C_SPLIT;
					nxt = ffha_pkg::S_SPLIT;
				end else begin
					cmd = ffha_pkg::C_ADV;
					if (st.at_end) begin
						status_d = ffha_pkg::ST_NOFIT;
						nxt = ffha_pkg::S_DONE;
					end else begin
						nxt = ffha_pkg::S_ARD;
					end
				end
			end
			ffha_pkg::S_SPLIT: begin
				cmd = ffha_pkg::C_RL_RD;
				nxt = ffha_pkg::S_RLRD;
			end
			ffha_pkg::S_RLRD: nxt = ffha_pkg::S_RLWR;
			ffha_pkg::S_RLWR: begin
				cmd = ffha_pkg::C_RL_WR;
				nxt = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_FRD: begin
				if (st.addr_bad) begin
					status_d = ffha_pkg::ST_RANGE;
					nxt = ffha_pkg::S_DONE;
				end else begin
					nxt = ffha_pkg::S_FEVAL;
				end
			end
			ffha_pkg::S_FEVAL: begin
				if (st.on_target) begin
					if (st.hdr_free) begin
						status_d = ffha_pkg::ST_FREED;
						nxt = ffha_pkg::S_DONE;
					end else begin
						cmd = ffha_pkg::C_RD_NX;
						nxt = ffha_pkg::S_NXRD;
					end
				end else if (st.past_target || st.at_end) begin
					status_d = ffha_pkg::ST_RANGE;
					nxt = ffha_pkg::S_DONE;
				end else begin
					cmd = ffha_pkg::C_ADV;
					nxt = ffha_pkg::S_FRD;
				end
			end
			ffha_pkg::S_NXRD: begin
				cmd = ffha_pkg::C_NX_EVAL;
				nxt = ffha_pkg::S_PVRD;
			end
			ffha_pkg::S_PVRD: begin
				cmd = ffha_pkg::C_RD_PV;
				nxt = ffha_pkg::S_MERGE;
			end
			ffha_pkg::S_MERGE: begin
				cmd = ffha_pkg::C_PV_EVAL;
				nxt = ffha_pkg::S_FWR;
			end
			ffha_pkg::S_FWR: begin
				cmd = ffha_pkg::C_FREE_WR;
				nxt = ffha_pkg::S_RLRD;
			end
			ffha_pkg::S_DONE: nxt = ffha_pkg::S_IDLE;
			default: nxt = ffha_pkg::S_IDLE;
		endcase
	end

	assign busy = (state_q != ffha_pkg::S_IDLE) || cfg_we;
	assign done = (state_q == ffha_pkg::S_DONE);
	assign status = status_q;

	`FFH_ASSERT(a_onehot, clk, arst_n, $onehot(state_q))
	`FFH_ASSERT(a_done_once, clk, arst_n, done |=> !done)
	`FFH_ASSERT(a_free_ok_zero, clk, arst_n,
		(done && status_q == ffha_pkg::ST_ZERO) |-> !is_free_q)
endmodule

[rtl/ffha_dp.sv]
module ffha_dp #(
	parameter int unsigned HEAP_UNITS = 4096,
	parameter int unsigned OffW = $clog2(HEAP_UNITS),
	parameter int unsigned CntW = $clog2(HEAP_UNITS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffha_pkg::cmd_t  cmd,
	input  logic            start_go,
	input  logic [11:0]     request_units,
	input  logic [16:0]     payload_address,
	input  logic            cfg_we,
	input  logic [ffha_pkg::RegIdxW-1:0] cfg_idx,
	input  logic [15:0]     cfg_data,
	input  logic            done,
	input  logic [ffha_pkg::StatusW-1:0] status,
	output ffha_pkg::stat_t st,
	output logic [16:0]     result_address
);
	// header: free, prev_valid, prev, size
	localparam int unsigned HW = 2 + 2 * OffW;
	logic [HW-1:0] mem [HEAP_UNITS];
	logic [HW-1:0] rd_q;
	logic [15:0] base_q;
	logic [12:0] units_cfg_q;
	logic [CntW-1:0] n_q;
	logic [CntW-1:0] off_q, tgt_q, nx_q, nw_q;
	logic [11:0] req_q;
	logic [OffW-1:0] cur_size_q, pv_q;
	logic pv_valid_q;
	logic addr_bad_q;
	logic we;
	logic [OffW-1:0] wa, ra;
	logic [HW-1:0] wd;
	logic re;

	logic rd_free, rd_pvv;
	logic [OffW-1:0] rd_pv, rd_size;
	logic [CntW:0] nxt_off;
	logic [17:0] tgt_full;
	logic [CntW-1:0] clamp_n;

	assign rd_free = rd_q[HW-1];
	assign rd_pvv = rd_q[HW-2];
	assign rd_pv = rd_q[2*OffW-1:OffW];
	assign rd_size = rd_q[OffW-1:0];
	assign nxt_off = {1'b0, off_q} + {1'b0, {(CntW-OffW){1'b0}}, rd_size} + 1'b1;
	assign tgt_full = {1'b0, payload_address} - {2'b00, base_q} - 18'd1;

	always_comb begin
		if ({19'd0, units_cfg_q} < 32'd2) clamp_n = CntW'(2);
		else if ({19'd0, units_cfg_q} > 32'(HEAP_UNITS)) clamp_n = CntW'(HEAP_UNITS);
		else clamp_n = CntW'(units_cfg_q);
	end

	always_comb begin
		st = '0;
		st.hdr_free = rd_free;
		st.fits_exact = ({{(32-OffW){1'b0}}, rd_size} == {20'd0, req_q});
		st.fits_split = ({{(32-OffW){1'b0}}, rd_size} > {20'd0, req_q} + 32'd2);
		st.at_end = (nxt_off >= {1'b0, n_q});
		st.on_target = (off_q == tgt_q);
		st.past_target = (off_q > tgt_q);
		st.rl_in = (nw_q < n_q);
		st.pv_ok = pv_valid_q && ({{(CntW-OffW){1'b0}}, pv_q} < n_q) && rd_free;
		st.addr_bad = addr_bad_q;
	end

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = off_q[OffW-1:0];
		case (cmd)
			ffha_pkg::C_INIT: begin
				we = 1'b1;
				wa = '0;
				wd = {1'b1, 1'b0, {OffW{1'b0}}, OffW'(clamp_n - 1'b1)};
			end
			ffha_pkg::C_RD_OFF: begin
				re = 1'b1;
				ra = '0;
			end
			ffha_pkg::C_ADV: begin
				re = !st.at_end;
				ra = nxt_off[OffW-1:0];
			end
			ffha_pkg::C_EXACT: begin
				we = 1'b1;
				wa = off_q[OffW-1:0];
				wd = {1'b0, rd_q[HW-2:0]};
			end
			ffha_pkg::C_SPLIT: begin
				we = 1'b1;
				wa = off_q[OffW-1:0];
				wd = {1'b0, rd_pvv, rd_pv, OffW'(req_q)};
			end
			ffha_pkg::C_RL_RD: begin
				we = 1'b1;
				wa = OffW'(off_q + CntW'(req_q) + 1'b1);
				wd = {1'b1, 1'b1, off_q[OffW-1:0], OffW'(rd_size - OffW'(req_q) - 1'b1)};
			end
			ffha_pkg::C_RL_WR: begin
				we = st.rl_in;
				wa = nw_q[OffW-1:0];
				wd = {rd_free, 1'b1, nx_q[OffW-1:0], rd_size};
			end
			ffha_pkg::C_RD_NX: begin
				re = 1'b1;
				ra = nxt_off[OffW-1:0];
			end
			ffha_pkg::C_NX_EVAL: begin
				re = 1'b1;
				ra = pv_q;
			end
			ffha_pkg::C_RD_PV: ;
			ffha_pkg::C_PV_EVAL: ;
			ffha_pkg::C_FREE_WR: begin
				we = 1'b1;
				wa = off_q[OffW-1:0];
				wd = {1'b1, pv_valid_q, pv_q, cur_size_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
		else if (cmd == ffha_pkg::C_RL_RD) rd_q <= mem[OffW'(nw_q)];
		else if (cmd == ffha_pkg::C_FREE_WR) rd_q <= mem[OffW'(nx_q)];
	end

	// free path ends with nw_q = next, nx_q = merged block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			units_cfg_q <= 13'd4096;
			n_q <= CntW'(HEAP_UNITS);
			off_q <= '0;
			tgt_q <= '0;
			nx_q <= '0;
			nw_q <= '0;
			req_q <= '0;
			cur_size_q <= '0;
			pv_q <= '0;
			pv_valid_q <= 1'b0;
			addr_bad_q <= 1'b0;
			result_address <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == ffha_pkg::REG_BASE) base_q <= cfg_data;
				else units_cfg_q <= cfg_data[12:0];
			end
			if (cmd == ffha_pkg::C_INIT) n_q <= clamp_n;
			if (start_go) begin
				off_q <= '0;
				req_q <= request_units;
				tgt_q <= tgt_full[CntW-1:0];
				addr_bad_q <= tgt_full[17] || (tgt_full[16:0] >= {{(17-CntW){1'b0}}, n_q});
			end
			case (cmd)
				ffha_pkg::C_ADV: off_q <= nxt_off[CntW-1:0];
				ffha_pkg::C_SPLIT: begin
					nx_q <= off_q + CntW'(req_q) + 1'b1;
					nw_q <= CntW'(nxt_off);
				end
				ffha_pkg::C_RD_NX: begin
					cur_size_q <= rd_size;
					pv_valid_q <= rd_pvv;
					pv_q <= rd_pv;
					nx_q <= nxt_off[CntW-1:0];
				end
				ffha_pkg::C_NX_EVAL: begin
					if (nx_q < n_q && rd_free) begin
						cur_size_q <= cur_size_q + rd_size + 1'b1;
						nx_q <= nx_q + CntW'(rd_size) + 1'b1;
					end
				end
				ffha_pkg::C_PV_EVAL: begin
					if (st.pv_ok) begin
						off_q <= {{(CntW-OffW){1'b0}}, pv_q};
						cur_size_q <= rd_size + cur_size_q + 1'b1;
						pv_valid_q <= rd_pvv;
						pv_q <= rd_pv;
					end
				end
				ffha_pkg::C_FREE_WR: begin
					nw_q <= nx_q;
					nx_q <= off_q;
				end
				default: ;
			endcase
			if (cmd == ffha_pkg::C_EXACT || cmd == ffha_pkg::C_SPLIT)
				result_address <= 17'({1'b0, base_q} + 17'(off_q) + 17'd1);
			else if (done && status != ffha_pkg::ST_OK)
				result_address <= '0;
			else if (start_go)
				result_address <= '0;
		end
	end
endmodule

[test/first_fit_heap_allocator_top_test.sv]
`timescale 1ns / 100ps
module first_fit_heap_allocator_top_test;
	localparam int unsigned DEPTH = 4096;
	localparam int unsigned CYCLE_LIMIT = 5000000;

	typedef struct {
		logic [16:0] address;
		logic [2:0]  code;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        operation;
	logic [11:0] request_units;
	logic [16:0] payload_address;
	logic        done;
	logic [16:0] result_address;
	logic [2:0]  status;
	logic        cfg_we;
	logic [ffha_pkg::RegIdxW-1:0] cfg_idx;
	logic [15:0] cfg_data;

	first_fit_heap_allocator_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
		.request_units(request_units), .payload_address(payload_address), .done(done),
		.result_address(result_address), .status(status), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// allocator image
	bit          blk_free [DEPTH];
	int unsigned blk_size [DEPTH];
	bit          blk_has_prev [DEPTH];
	int unsigned blk_prev [DEPTH];
	int unsigned base_addr;
	int unsigned units_reg;

	outcome_t    pending_results[$];
	logic [16:0] live_blocks[$];
	logic [16:0] last_released;
	int          mismatches = 0;
	int          results_seen = 0;
	int          items_sent;
	int          status_hits [5];
	int unsigned cycles = 0;
	bit          no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int unsigned heap_span();
		int unsigned u;
		u = units_reg;
		if (u < 2) u = 2;
		if (u > DEPTH) u = DEPTH;
		return u;
	endfunction

	function automatic void rebuild_heap();
		for (int i = 0; i < DEPTH; i++) begin
			blk_free[i] = 1'b0;
			blk_size[i] = 0;
			blk_has_prev[i] = 1'b0;
			blk_prev[i] = 0;
		end
		blk_free[0] = 1'b1;
		blk_size[0] = heap_span() - 1;
		live_blocks.delete();
	endfunction

	function automatic void link_successor(int unsigned off, int unsigned n);
		int unsigned nx;
		nx = off + 1 + blk_size[off];
		if (nx < n) begin
			blk_has_prev[nx] = 1'b1;
			blk_prev[nx] = off;
		end
	endfunction

	function automatic outcome_t allocate_block(int unsigned req);
		outcome_t r;
		int unsigned n, off, nw;
		n = heap_span();
		off = 0;
		r.address = '0;
		r.code = ffha_pkg::ST_NOFIT;
		if (req == 0) begin
			r.code = ffha_pkg::ST_ZERO;
			return r;
		end
		while (off < n) begin
			if (blk_free[off]) begin
				if (blk_size[off] == req) begin
					blk_free[off] = 1'b0;
					r.address = 17'(base_addr + off + 1);
					r.code = ffha_pkg::ST_OK;
					return r;
				end
				if (blk_size[off] > req + 2) begin
					nw = off + 1 + req;
					blk_free[nw] = 1'b1;
					blk_size[nw] = blk_size[off] - req - 1;
					blk_has_prev[nw] = 1'b1;
					blk_prev[nw] = off;
					link_successor(nw, n);
					blk_free[off] = 1'b0;
					blk_size[off] = req;
					r.address = 17'(base_addr + off + 1);
					r.code = ffha_pkg::ST_OK;
					return r;
				end
			end
			off += blk_size[off] + 1;
		end
		return r;
	endfunction

	function automatic outcome_t release_block(int unsigned addr);
		outcome_t r;
		int unsigned n, off, target, nx, p;
		n = heap_span();
		off = 0;
		r.address = '0;
		r.code = ffha_pkg::ST_RANGE;
		if (addr < base_addr + 1) return r;
		target = addr - base_addr - 1;
		if (target >= n) return r;
		while (off < n && off < target) off += blk_size[off] + 1;
		if (off != target) return r;
		if (blk_free[off]) begin
			r.code = ffha_pkg::ST_FREED;
			return r;
		end
		nx = off + 1 + blk_size[off];
		if (nx < n && blk_free[nx]) blk_size[off] += blk_size[nx] + 1;
		if (blk_has_prev[off] && blk_prev[off] < n && blk_free[blk_prev[off]]) begin
			p = blk_prev[off];
			blk_size[p] += blk_size[off] + 1;
			off = p;
		end
		blk_free[off] = 1'b1;
		link_successor(off, n);
		r.code = ffha_pkg::ST_OK;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result addr=%0d status=%0d", result_address, status);
			end else begin
				want = pending_results.pop_front();
				if (result_address !== want.address || status !== want.code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
							want.address, want.code, result_address, status);
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic op, logic [11:0] req, logic [16:0] addr);
		outcome_t r;
		int unsigned gap;
		operation = op;
		request_units = req;
		payload_address = addr;
		start = 1'b1;
		do @(posedge clk); while (busy);
		if (op == ffha_pkg::OP_ALLOC) begin
			r = allocate_block(req);
			if (r.code == ffha_pkg::ST_OK) live_blocks.push_back(r.address);
		end else begin
			r = release_block(addr);
			if (r.code == ffha_pkg::ST_OK) begin
				last_released = addr;
				foreach (live_blocks[i])
					if (live_blocks[i] == addr) begin
						live_blocks.delete(i);
						break;
					end
			end
		end
		pending_results.push_back(r);
		status_hits[r.code]++;
		items_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_register(logic [ffha_pkg::RegIdxW-1:0] idx, logic [15:0] value);
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value;
		if (idx == ffha_pkg::REG_BASE) base_addr = value;
		else units_reg = value & 16'h1FFF;
		rebuild_heap();
		@(negedge clk);
		cfg_we = 1'b0;
		repeat (3) @(negedge clk);
	endtask

	task automatic test_alloc_special_cases();
		send_item(ffha_pkg::OP_ALLOC, 12'd0, 17'h1FFFF);
		send_item(ffha_pkg::OP_ALLOC, 12'hFFF, 17'd0);
		send_item(ffha_pkg::OP_ALLOC, 12'd5, 17'h15555);
		send_item(ffha_pkg::OP_ALLOC, 12'd8, 17'h0AAAA);
		send_item(ffha_pkg::OP_ALLOC, 12'd7, 17'd0);
		send_item(ffha_pkg::OP_ALLOC, 12'd9, 17'd0);
	endtask

	task automatic test_free_special_cases();
		send_item(ffha_pkg::OP_FREE, 12'hFFF, 17'(base_addr + 7));
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'(base_addr + 7));
		send_item(ffha_pkg::OP_FREE, 12'hAAA, 17'(base_addr));
		send_item(ffha_pkg::OP_FREE, 12'h555, 17'(base_addr + heap_span() + 1));
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'(base_addr + 3));
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'h1FFFF);
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'd0);
	endtask

	task automatic test_coalescing();
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'(base_addr + 1));
		send_item(ffha_pkg::OP_ALLOC, 12'd3, 17'd0);
		send_item(ffha_pkg::OP_ALLOC, 12'd3, 17'd0);
		send_item(ffha_pkg::OP_ALLOC, 12'd3, 17'd0);
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'(base_addr + 1));
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'(base_addr + 9));
		send_item(ffha_pkg::OP_FREE, 12'd0, 17'(base_addr + 5));
		send_item(ffha_pkg::OP_ALLOC, 12'd15, 17'd0);
	endtask

	task automatic test_random_traffic(int count, int unsigned max_req);
		int unsigned r;
		for (int k = 0; k < count; k++) begin
			if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 40 && live_blocks.size() != 0)
				send_item(ffha_pkg::OP_FREE, 12'($urandom),
					live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
			else if (r < 80)
				send_item(ffha_pkg::OP_ALLOC, 12'($urandom_range(1, max_req)), 17'($urandom));
			else if (r < 84)
				send_item(ffha_pkg::OP_ALLOC, 12'($urandom), 17'($urandom));
			else if (r < 87)
				send_item(ffha_pkg::OP_ALLOC, 12'd0, 17'($urandom));
			else if (r < 91)
				send_item(ffha_pkg::OP_FREE, 12'($urandom), last_released);
			else if (r < 95)
				send_item(ffha_pkg::OP_FREE, 12'($urandom),
					17'(base_addr + $urandom_range(0, heap_span() + 2)));
			else
				send_item(ffha_pkg::OP_FREE, 12'($urandom), 17'($urandom));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = ffha_pkg::OP_ALLOC;
		request_units = '0;
		payload_address = '0;
		cfg_we = 1'b0;
		cfg_idx = ffha_pkg::REG_BASE;
		cfg_data = '0;
		items_sent = 0;
		no_gaps = 1'b0;
		last_released = '0;
		foreach (status_hits[i]) status_hits[i] = 0;
		base_addr = 0;
		units_reg = 4096;
		rebuild_heap();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		test_random_traffic(20, 40);
		write_register(ffha_pkg::REG_BASE, 16'd100);
		write_register(ffha_pkg::REG_UNITS, 16'd16);
		test_alloc_special_cases();
		test_free_special_cases();
		test_coalescing();
		write_register(ffha_pkg::REG_BASE, 16'd0);
		write_register(ffha_pkg::REG_UNITS, 16'd64);
		test_random_traffic(150, 12);
		write_register(ffha_pkg::REG_BASE, 16'hFFFF);
		write_register(ffha_pkg::REG_UNITS, 16'd2);
		test_random_traffic(40, 3);
		write_register(ffha_pkg::REG_UNITS, 16'd8191);
		test_random_traffic(140, 200);
		write_register(ffha_pkg::REG_BASE, 16'd31000);
		write_register(ffha_pkg::REG_UNITS, 16'd300);
		test_random_traffic(240, 30);
		write_register(ffha_pkg::REG_UNITS, 16'hE000);
		test_random_traffic(20, 3);
		write_register(ffha_pkg::REG_UNITS, 16'd1000);
		test_random_traffic(150, 60);

		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("%0d requests, %0d results over eight heap layouts", items_sent, results_seen);
		$display("outcomes: ok %0d, no fit %0d, zero %0d, double free %0d, bad address %0d",
			status_hits[ffha_pkg::ST_OK], status_hits[ffha_pkg::ST_NOFIT],
			status_hits[ffha_pkg::ST_ZERO], status_hits[ffha_pkg::ST_FREED],
			status_hits[ffha_pkg::ST_RANGE]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator_top.sv
test/first_fit_heap_allocator_top_test.sv
